[hw/rtl/lsh_pkg.sv]
package lsh_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_CHANNELS = 4;

	localparam int SAMPLE_W = 8;
	localparam int CFG_W_W  = 11;
	localparam int CFG_H_W  = 12;
	localparam int CFG_C_W  = 3;
	localparam int MIN_DIM  = 3;

	// one line word covers one sample slot of a row
	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int ROW_W      = CFG_H_W;
	localparam int SPR_W      = $clog2(LINE_DEPTH + 1);
	localparam int LAG_W      = $clog2(LINE_DEPTH + MAX_CHANNELS + 1);
	localparam int CH_W       = $clog2(MAX_CHANNELS + 1);
	localparam int CHI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int ACC_W = SAMPLE_W + 4;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 3);

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH   = 2'd0;
	localparam reg_idx_t REG_FRAME_HEIGHT  = 2'd1;
	localparam reg_idx_t REG_CHANNEL_COUNT = 2'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [CH_W-1:0]  chan;
		logic [CHI_W-1:0] chan_m1;
		logic [COL_W-1:0] s_m1;
		logic [COL_W-1:0] s_mc;
		logic [LAG_W-1:0] s_pc;
		logic [ROW_W-1:0] h_m1;
	} geom_t;

	typedef struct packed {
		logic emit;
		logic zero;
		logic last;
	} ctl_t;

	typedef struct packed {
		sample_t up;
		sample_t left;
		sample_t centre;
		sample_t right;
		sample_t down;
	} taps_t;

	typedef struct packed {
		sample_t newer;
		sample_t older;
	} line_word_t;

	typedef struct packed {
		sample_t value;
		logic    frame_end;
	} result_t;

endpackage

[hw/rtl/lsh_if.sv]
interface lsh_in_if;
	import lsh_pkg::*;

	logic    valid;
	logic    ready;
	logic    cmd;
	sample_t sample;

	modport source(output valid, output cmd, output sample, input ready);
	modport sink(input valid, input cmd, input sample, output ready);
endinterface

interface lsh_out_if;
	import lsh_pkg::*;

	logic    valid;
	logic    ready;
	sample_t value;
	logic    frame_end;

	modport source(output valid, output value, output frame_end, input ready);
	modport sink(input valid, input value, input frame_end, output ready);
endinterface

[hw/rtl/lsh_cfg.sv]
module lsh_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lsh_pkg::PADDR_W-1:0]    paddr,
	input  logic [lsh_pkg::PDATA_W-1:0]    pwdata,
	output logic [lsh_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	output lsh_pkg::geom_t                 geom,
	output logic                           restart
);
	import lsh_pkg::*;

	localparam logic [CFG_W_W-1:0] RESET_W = CFG_W_W'(640);
	localparam logic [CFG_H_W-1:0] RESET_H = CFG_H_W'(480);
	localparam logic [CFG_C_W-1:0] RESET_C = CFG_C_W'(1);

	function automatic geom_t geom_of(logic [CFG_W_W-1:0] w, logic [CFG_H_W-1:0] h,
		logic [CFG_C_W-1:0] c);
		logic [CFG_W_W-1:0] w_eff;
		logic [CFG_H_W-1:0] h_eff;
		logic [CH_W-1:0]    c_eff;
		logic [SPR_W-1:0]   spr;
		geom_t              g;
		if (w < CFG_W_W'(MIN_DIM)) begin
			w_eff = CFG_W_W'(MIN_DIM);
		end else if (w > CFG_W_W'(MAX_WIDTH)) begin
			w_eff = CFG_W_W'(MAX_WIDTH);
		end else begin
			w_eff = w;
		end
		h_eff = (h < CFG_H_W'(MIN_DIM)) ? CFG_H_W'(MIN_DIM) : h;
		if (c == '0) begin
			c_eff = CH_W'(1);
		end else if (c > CFG_C_W'(MAX_CHANNELS)) begin
			c_eff = CH_W'(MAX_CHANNELS);
		end else begin
			c_eff = CH_W'(c);
		end
		spr       = SPR_W'(SPR_W'(w_eff) * SPR_W'(c_eff));
		g.chan    = c_eff;
		g.chan_m1 = CHI_W'(c_eff - CH_W'(1));
		g.s_m1    = COL_W'(spr - SPR_W'(1));
		g.s_mc    = COL_W'(spr - SPR_W'(c_eff));
		g.s_pc    = LAG_W'(spr) + LAG_W'(c_eff);
		g.h_m1    = h_eff - CFG_H_W'(1);
		return g;
	endfunction

	logic [CFG_W_W-1:0] width_q, width_n;
	logic [CFG_H_W-1:0] height_q, height_n;
	logic [CFG_C_W-1:0] chan_q, chan_n;
	geom_t              geom_q;
	reg_idx_t           idx;
	logic               wr;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_comb begin
		width_n  = width_q;
		height_n = height_q;
		chan_n   = chan_q;
		restart  = 1'b0;
		if (wr) begin
			unique case (idx)
				REG_FRAME_WIDTH: begin
					width_n = pwdata[CFG_W_W-1:0];
					restart = 1'b1;
				end
				REG_FRAME_HEIGHT: begin
					height_n = pwdata[CFG_H_W-1:0];
					restart  = 1'b1;
				end
				REG_CHANNEL_COUNT: begin
					chan_n  = pwdata[CFG_C_W-1:0];
					restart = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// derive from the incoming value so the next request already sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_W;
			height_q <= RESET_H;
			chan_q   <= RESET_C;
			geom_q   <= geom_of(RESET_W, RESET_H, RESET_C);
		end else begin
			width_q  <= width_n;
			height_q <= height_n;
			chan_q   <= chan_n;
			geom_q   <= geom_of(width_n, height_n, chan_n);
		end
	end

	assign geom = geom_q;

	always_comb begin
		unique case (idx)
			REG_FRAME_WIDTH:   prdata = PDATA_W'(width_q);
			REG_FRAME_HEIGHT:  prdata = PDATA_W'(height_q);
			REG_CHANNEL_COUNT: prdata = PDATA_W'(chan_q);
			default:           prdata = '0;
		endcase
	end

endmodule

[hw/rtl/lsh_ctrl.sv]
module lsh_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic                       cmd,
	input  lsh_pkg::geom_t             geom,
	input  logic                       restart,
	output logic [lsh_pkg::COL_W-1:0]  col,
	output lsh_pkg::ctl_t              ctl_s1,
	output lsh_pkg::ctl_t              ctl_s2
);
	import lsh_pkg::*;

	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [LAG_W-1:0] lag_q;
	logic             is_smp, behind, emit, zero, last;
	ctl_t             ctl_s1_q, ctl_s2_q;

	assign is_smp = (cmd == CMD_SAMPLE);

	// output still in the previous frame while input already wrapped
	assign behind = (out_row_q > in_row_q) ||
		((out_row_q == in_row_q) && (out_col_q > in_col_q));
	assign emit = behind || (is_smp && (lag_q >= geom.s_pc));
	assign zero = behind || (out_row_q == '0) || (out_row_q == geom.h_m1) ||
		(out_col_q < COL_W'(geom.chan)) || (out_col_q >= geom.s_mc);
	assign last = (out_row_q == geom.h_m1) && (out_col_q == geom.s_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			lag_q     <= '0;
		end else if (restart) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			lag_q     <= '0;
		end else if (acc) begin
			if (is_smp) begin
				if (in_col_q == geom.s_m1) begin
					in_col_q <= '0;
					in_row_q <= (in_row_q == geom.h_m1) ? '0 : in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (emit) begin
				if (out_col_q == geom.s_m1) begin
					out_col_q <= '0;
					out_row_q <= (out_row_q == geom.h_m1) ? '0 : out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			lag_q <= lag_q + LAG_W'(is_smp) - LAG_W'(emit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1_q <= '0;
			ctl_s2_q <= '0;
		end else begin
			ctl_s1_q.emit <= acc & emit;
			ctl_s1_q.zero <= zero;
			ctl_s1_q.last <= last;
			ctl_s2_q      <= ctl_s1_q;
		end
	end

	assign col    = in_col_q;
	assign ctl_s1 = ctl_s1_q;
	assign ctl_s2 = ctl_s2_q;

endmodule

[hw/rtl/lsh_line.sv]
module lsh_line (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [lsh_pkg::COL_W-1:0]   rd_addr,
	input  lsh_pkg::sample_t            sample,
	input  logic [lsh_pkg::CHI_W-1:0]   chan_m1,
	output lsh_pkg::taps_t              taps_s2
);
	import lsh_pkg::*;

	line_word_t       mem [LINE_DEPTH];
	line_word_t       rd_q;
	logic             wr_s1;
	logic [COL_W-1:0] addr_s1;
	sample_t          sample_s1;

	// one pixel delay lines, tap at chan_m1
	sample_t xch_q [MAX_CHANNELS];
	sample_t ach_q [MAX_CHANNELS];
	sample_t cch_q [MAX_CHANNELS];
	sample_t bch_q [MAX_CHANNELS];

	taps_t taps, taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= rd_en;
		end
	end

	// read at accept, write back in the following cycle; consecutive samples
	// hit different columns since a row holds at least three samples
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_s1) begin
			mem[addr_s1] <= '{newer: sample_s1, older: rd_q.newer};
		end
		addr_s1   <= rd_addr;
		sample_s1 <= sample;
	end

	always_comb begin
		taps.up     = bch_q[chan_m1];
		taps.left   = cch_q[chan_m1];
		taps.centre = ach_q[chan_m1];
		taps.right  = rd_q.newer;
		taps.down   = xch_q[chan_m1];
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			xch_q[0] <= sample_s1;
			ach_q[0] <= rd_q.newer;
			cch_q[0] <= taps.centre;
			bch_q[0] <= rd_q.older;
			for (int i = 1; i < MAX_CHANNELS; i++) begin
				xch_q[i] <= xch_q[i-1];
				ach_q[i] <= ach_q[i-1];
				cch_q[i] <= cch_q[i-1];
				bch_q[i] <= bch_q[i-1];
			end
		end
		taps_q <= taps;
	end

	assign taps_s2 = taps_q;

endmodule

[hw/rtl/lsh_outq.sv]
module lsh_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  lsh_pkg::ctl_t     ctl_s1,
	input  lsh_pkg::ctl_t     ctl_s2,
	input  lsh_pkg::taps_t    taps_s2,
	output logic              room,
	lsh_out_if.source         results
);
	import lsh_pkg::*;

	logic [ACC_W-1:0] sum;
	logic             neg, over;
	result_t          res;
	result_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q, pending;
	logic             push, pop;

	assign sum = (ACC_W'(taps_s2.centre) << 2) + ACC_W'(taps_s2.centre)
		- ACC_W'(taps_s2.up) - ACC_W'(taps_s2.down)
		- ACC_W'(taps_s2.left) - ACC_W'(taps_s2.right);
	assign neg  = sum[ACC_W-1];
	assign over = !neg && (sum[ACC_W-2:SAMPLE_W] != '0);

	always_comb begin
		priority if (ctl_s2.zero || neg) begin
			res.value = '0;
		end else if (over) begin
			res.value = '1;
		end else begin
			res.value = sum[SAMPLE_W-1:0];
		end
		res.frame_end = ctl_s2.last;
	end

	assign push = ctl_s2.emit;
	assign pop  = results.valid & results.ready;

	// hold back requests once queue plus results in flight would fill it
	assign pending = cnt_q + OQ_CW'(ctl_s1.emit) + OQ_CW'(ctl_s2.emit);
	assign room    = pending < OQ_CW'(OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			cnt_q <= cnt_q + OQ_CW'(push) - OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[wr_ptr_q] <= res;
		end
	end

	assign results.valid     = (cnt_q != '0);
	assign results.value     = oq_q[rd_ptr_q].value;
	assign results.frame_end = oq_q[rd_ptr_q].frame_end;

endmodule

[hw/rtl/laplacian_sharpen_3x3.sv]
// channel   dir  payload                        handshake
// samples   in   cmd[0], sample[7:0]            valid/ready
// results   out  value[7:0], frame_end          valid/ready
// apb       in   paddr[3:0], pwdata[31:0]       psel/penable, pready tied high
//
// One request per cycle while ready is high; results pass the s1 and s2 stages
// into the output queue. The line memory is read when a sample is taken and
// written back the next cycle, one port each, so it never limits the rate.
// Reset clears positions and queue; the line memory is not cleared and needs
// no sweep. A register write restarts the stream. Results wait in a 4-entry
// queue; ready drops only when queue and pipeline together would exceed it.
module laplacian_sharpen_3x3 (
	input  logic                           clk,
	input  logic                           arst_n,
	lsh_in_if.sink                         samples,
	lsh_out_if.source                      results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lsh_pkg::PADDR_W-1:0]    paddr,
	input  logic [lsh_pkg::PDATA_W-1:0]    pwdata,
	output logic [lsh_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import lsh_pkg::*;

	geom_t            geom;
	logic             restart;
	logic             acc;
	logic             room;
	logic [COL_W-1:0] col;
	ctl_t             ctl_s1, ctl_s2;
	taps_t            taps_s2;

	assign samples.ready = room;
	assign acc           = samples.valid & samples.ready;

	lsh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom),
		.restart (restart)
	);

	lsh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.cmd     (samples.cmd),
		.geom    (geom),
		.restart (restart),
		.col     (col),
		.ctl_s1  (ctl_s1),
		.ctl_s2  (ctl_s2)
	);

	lsh_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc & (samples.cmd == CMD_SAMPLE)),
		.rd_addr (col),
		.sample  (samples.sample),
		.chan_m1 (geom.chan_m1),
		.taps_s2 (taps_s2)
	);

	lsh_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.ctl_s2  (ctl_s2),
		.taps_s2 (taps_s2),
		.room    (room),
		.results (results)
	);

endmodule

[hw/rtl/lsh_checker.sv]
module lsh_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [lsh_pkg::SAMPLE_W-1:0] out_value,
	input logic                     out_frame_end
);
	import lsh_pkg::*;

	logic in_acc;

	assign in_acc = in_valid & in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_frame_end))
		else $error("result changed while stalled");

	// an empty result side must never block requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with no result waiting");

	// nothing can surface without a request inside the pipeline depth
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_acc && !$past(in_acc) && !$past(in_acc, 2) |=> !out_valid)
		else $error("result without a request");

endmodule

bind laplacian_sharpen_3x3 lsh_checker u_lsh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_value     (results.value),
	.out_frame_end (results.frame_end)
);
